// ===== rtl/core/rwx_pkg.sv =====
package rwx_pkg;

	localparam int NUM_GROUPS_DEF        = 8;
	localparam int MEMBERS_PER_GROUP_DEF = 16;
	localparam int USER_W                = 8;

	localparam logic [2:0] RWX_MASK    = 3'h7;
	localparam int         OWNER_SHIFT = 6;
	localparam int         GROUP_SHIFT = 3;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_ADD    = 2'd1,
		OP_CHECK  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EXEC = 2'd1,
		ST_SCAN = 2'd2,
		ST_DONE = 2'd3
	} state_t;

	typedef enum logic [1:0] {
		TRI_OWNER  = 2'd0,
		TRI_GROUP  = 2'd1,
		TRI_OTHERS = 2'd2
	} triple_t;

	typedef struct packed {
		op_t              op;
		logic [2:0]       group_index;
		logic [USER_W-1:0] user_id;
		logic [USER_W-1:0] caller_group;
		logic [USER_W-1:0] owner_user;
		logic [USER_W-1:0] owner_group;
		logic [8:0]       mode_bits;
		logic [2:0]       wanted;
	} req_t;

	typedef struct packed {
		logic       status;
		logic       allowed;
		logic [2:0] new_group;
	} rsp_t;

	function automatic logic triple_ok(logic [8:0] mode, triple_t sel, logic [2:0] want);
		logic [8:0] sh;
		logic [2:0] granted;
		case (sel)
			TRI_OWNER: sh = mode >> OWNER_SHIFT;
			TRI_GROUP: sh = mode >> GROUP_SHIFT;
			default:   sh = mode;
		endcase
		granted = sh[2:0] & RWX_MASK;
		return (granted & want) == want;
	endfunction

endpackage

// ===== rtl/core/rwx_member_store.sv =====
module rwx_member_store
	import rwx_pkg::*;
#(
	parameter int NUM_GROUPS        = NUM_GROUPS_DEF,
	parameter int MEMBERS_PER_GROUP = MEMBERS_PER_GROUP_DEF,
	localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1,
	localparam int KW = (MEMBERS_PER_GROUP > 1) ? $clog2(MEMBERS_PER_GROUP) : 1,
	localparam int CW = $clog2(MEMBERS_PER_GROUP + 1)
) (
	input  logic              clk,
	input  logic [GW-1:0]     grp,
	input  logic              cnt_rd_en,
	input  logic [GW-1:0]     cnt_rd_grp,
	output logic [CW-1:0]     cnt_rd_data,
	input  logic              cnt_wr_en,
	input  logic [CW-1:0]     cnt_wr_data,
	input  logic              lst_wr_en,
	input  logic [KW-1:0]     lst_wr_idx,
	input  logic [USER_W-1:0] lst_wr_data,
	input  logic              lst_rd_en,
	input  logic [KW-1:0]     lst_rd_idx,
	output logic [USER_W-1:0] lst_rd_data
);

	logic [CW-1:0]     cnt_mem [NUM_GROUPS];
	logic [USER_W-1:0] lst_mem [NUM_GROUPS][MEMBERS_PER_GROUP];
	logic [CW-1:0]     cnt_rd_q;
	logic [USER_W-1:0] lst_rd_q;

	always_ff @(posedge clk) begin
		if (cnt_wr_en)
			cnt_mem[grp] <= cnt_wr_data;
		if (cnt_rd_en)
			cnt_rd_q <= cnt_mem[cnt_rd_grp];
	end

	always_ff @(posedge clk) begin
		if (lst_wr_en)
			lst_mem[grp][lst_wr_idx] <= lst_wr_data;
		if (lst_rd_en)
			lst_rd_q <= lst_mem[grp][lst_rd_idx];
	end

	assign cnt_rd_data = cnt_rd_q;
	assign lst_rd_data = lst_rd_q;

endmodule

// ===== rtl/core/rwx_permission_checker.sv =====
// Unix-style rwx access checker with a group membership table. Each transaction is
// one op: create group, add member, check access or a reserved op, and yields exactly one response.
// The block takes one transaction at a time. Create, add, reserved op and a check
// decided without the member list go from the exec state to the done state, where the
// response is loaded into the output register, and the block then returns to idle to
// accept the next request. A check that consults the owning group's list walks it one
// entry per cycle through the single list read port and compare, reading up to
// MEMBERS_PER_GROUP entries in the scan state before the done state. A stalled
// response holds the block in its done state. A new request is accepted while an
// earlier response still waits in the output register.
module rwx_permission_checker
	import rwx_pkg::*;
#(
	parameter int NUM_GROUPS        = NUM_GROUPS_DEF,
	parameter int MEMBERS_PER_GROUP = MEMBERS_PER_GROUP_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int UW = $clog2(NUM_GROUPS + 1);
	localparam int KW = (MEMBERS_PER_GROUP > 1) ? $clog2(MEMBERS_PER_GROUP) : 1;
	localparam int CW = $clog2(MEMBERS_PER_GROUP + 1);

	state_t            state_q, state_d;
	req_t              item_q;
	logic [GW-1:0]     grp_q, grp_in;
	logic              grp_ok_q, grp_ok_in;
	logic [UW-1:0]     gu_q, gu_d;
	logic [CW-1:0]     k_q, k_d, k_nx;
	rsp_t              res_q, res_d;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	logic              req_acc, rsp_load;
	logic [USER_W-1:0] sel_grp;
	logic [7:0]        gu_ext;

	logic [CW-1:0]     cnt_rd;
	logic              cnt_wr_en;
	logic [CW-1:0]     cnt_wr_data;
	logic              lst_wr_en;
	logic              lst_rd_en;
	logic [KW-1:0]     lst_rd_idx;
	logic [USER_W-1:0] lst_rd_data;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;

	assign sel_grp   = (req.op == OP_ADD) ? USER_W'(req.group_index) : req.owner_group;
	assign grp_in    = (req.op == OP_CREATE) ? GW'(gu_q) : GW'(sel_grp);
	assign grp_ok_in = (9'(sel_grp) < 9'(gu_q));
	assign gu_ext    = 8'(gu_q);
	assign k_nx      = k_q + CW'(1);

	rwx_member_store #(
		.NUM_GROUPS        (NUM_GROUPS),
		.MEMBERS_PER_GROUP (MEMBERS_PER_GROUP)
	) u_store (
		.clk         (clk),
		.grp         (grp_q),
		.cnt_rd_en   (req_acc),
		.cnt_rd_grp  (GW'(sel_grp)),
		.cnt_rd_data (cnt_rd),
		.cnt_wr_en   (cnt_wr_en),
		.cnt_wr_data (cnt_wr_data),
		.lst_wr_en   (lst_wr_en),
		.lst_wr_idx  (cnt_rd[KW-1:0]),
		.lst_wr_data (item_q.user_id),
		.lst_rd_en   (lst_rd_en),
		.lst_rd_idx  (lst_rd_idx),
		.lst_rd_data (lst_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gu_q    <= '0;
		end else begin
			state_q <= state_d;
			gu_q    <= gu_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			item_q   <= req;
			grp_q    <= grp_in;
			grp_ok_q <= grp_ok_in;
		end
		k_q   <= k_d;
		res_q <= res_d;
	end

	always_comb begin
		state_d     = state_q;
		res_d       = res_q;
		gu_d        = gu_q;
		k_d         = k_q;
		cnt_wr_en   = 1'b0;
		cnt_wr_data = '0;
		lst_wr_en   = 1'b0;
		lst_rd_en   = 1'b0;
		lst_rd_idx  = '0;
		rsp_load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_acc)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				res_d   = '{status: 1'b1, allowed: 1'b0, new_group: 3'd0};
				state_d = ST_DONE;
				case (item_q.op)
					OP_CREATE: begin
						if (gu_q < UW'(NUM_GROUPS)) begin
							res_d.status    = 1'b0;
							res_d.new_group = gu_ext[2:0];
							cnt_wr_en       = 1'b1;
							gu_d            = gu_q + UW'(1);
						end
					end
					OP_ADD: begin
						if (grp_ok_q && (cnt_rd < CW'(MEMBERS_PER_GROUP))) begin
							res_d.status = 1'b0;
							lst_wr_en    = 1'b1;
							cnt_wr_en    = 1'b1;
							cnt_wr_data  = cnt_rd + CW'(1);
						end
					end
					OP_CHECK: begin
						res_d.status = 1'b0;
						if (item_q.user_id == '0)
							res_d.allowed = 1'b1;
						else if (item_q.user_id == item_q.owner_user)
							res_d.allowed = triple_ok(item_q.mode_bits, TRI_OWNER, item_q.wanted);
						else if (item_q.caller_group == item_q.owner_group)
							res_d.allowed = triple_ok(item_q.mode_bits, TRI_GROUP, item_q.wanted);
						else if (grp_ok_q && (cnt_rd != '0)) begin
							lst_rd_en = 1'b1;
							k_d       = '0;
							state_d   = ST_SCAN;
						end else
							res_d.allowed = triple_ok(item_q.mode_bits, TRI_OTHERS, item_q.wanted);
					end
					default: ;
				endcase
			end
			ST_SCAN: begin
				if (lst_rd_data == item_q.user_id) begin
					res_d.allowed = triple_ok(item_q.mode_bits, TRI_GROUP, item_q.wanted);
					state_d       = ST_DONE;
				end else if (k_nx == cnt_rd) begin
					res_d.allowed = triple_ok(item_q.mode_bits, TRI_OTHERS, item_q.wanted);
					state_d       = ST_DONE;
				end else begin
					lst_rd_en  = 1'b1;
					lst_rd_idx = k_nx[KW-1:0];
					k_d        = k_nx;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (rsp_load)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (rsp_load)
			rsp_q <= res_q;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_gu_bound: assert property (@(posedge clk) disable iff (!arst_n)
		gu_q <= UW'(NUM_GROUPS))
		else $error("group count exceeds table size");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
		else $error("response raised outside done state");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> k_q < cnt_rd)
		else $error("member scan past list end");

	a_scan_only_check: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> (item_q.op == OP_CHECK) && grp_ok_q)
		else $error("member scan without a valid check transaction");

endmodule

// ===== bench/rwx_permission_checker_tb.sv =====
`timescale 1ns / 1ps

module rwx_permission_checker_tb;
	import rwx_pkg::*;

	localparam int GROUP_SLOTS = NUM_GROUPS_DEF;
	localparam int LIST_DEPTH  = MEMBERS_PER_GROUP_DEF;
	localparam int RAND_ITEMS  = 1225;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	rwx_permission_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// mirror of the block's group table
	logic [USER_W-1:0] member_tab [GROUP_SLOTS][LIST_DEPTH];
	int member_cnt [GROUP_SLOTS];
	int groups_made = 0;

	req_t request_q [$];
	rsp_t answer_q [$];
	logic [USER_W-1:0] user_pool [16];

	int errors = 0;
	int sent_cnt = 0;
	int got_cnt = 0;
	int idle_left = 0;
	int stall_left = 0;
	int n_create = 0, n_add = 0, n_add_fail = 0, n_check = 0, n_granted = 0, n_none = 0;
	int n_full_adds = 0;

	initial forever #4 clk = ~clk;

	function automatic rsp_t access_response(input req_t r);
		rsp_t a;
		logic [2:0] perm;
		bit in_grp;
		int gi;
		a = '0;
		a.status = 1'b1;
		gi = int'(r.group_index);
		case (r.op)
			OP_CREATE: begin
				if (groups_made < GROUP_SLOTS) begin
					a.new_group = groups_made[2:0];
					member_cnt[groups_made] = 0;
					groups_made++;
					a.status = 1'b0;
				end
			end
			OP_ADD: begin
				if (gi < groups_made && member_cnt[gi] < LIST_DEPTH) begin
					member_tab[gi][member_cnt[gi]] = r.user_id;
					member_cnt[gi]++;
					a.status = 1'b0;
				end
			end
			OP_CHECK: begin
				a.status = 1'b0;
				in_grp = 1'b0;
				if (r.owner_group < groups_made) begin
					for (int k = 0; k < member_cnt[r.owner_group]; k++)
						if (member_tab[r.owner_group][k] == r.user_id)
							in_grp = 1'b1;
				end
				if (r.user_id == '0) begin
					a.allowed = 1'b1;
				end else begin
					if (r.user_id == r.owner_user)
						perm = r.mode_bits[8:6];
					else if (r.caller_group == r.owner_group || in_grp)
						perm = r.mode_bits[5:3];
					else
						perm = r.mode_bits[2:0];
					a.allowed = ((perm & r.wanted) == r.wanted);
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	function automatic req_t make_req(input op_t op, input int gi, input int uid, input int cg,
			input int ou, input int og, input int mode, input int want);
		req_t r;
		r.op = op;
		r.group_index = gi[2:0];
		r.user_id = uid[7:0];
		r.caller_group = cg[7:0];
		r.owner_user = ou[7:0];
		r.owner_group = og[7:0];
		r.mode_bits = mode[8:0];
		r.wanted = want[2:0];
		return r;
	endfunction

	function automatic req_t random_req();
		req_t r;
		int sel;
		r.group_index = 3'($urandom_range(0, 7));
		r.user_id = 8'($urandom_range(0, 255));
		r.caller_group = 8'($urandom_range(0, 255));
		r.owner_user = 8'($urandom_range(0, 255));
		r.owner_group = 8'($urandom_range(0, 255));
		r.mode_bits = 9'($urandom_range(0, 511));
		r.wanted = 3'($urandom_range(0, 7));
		sel = $urandom_range(0, 99);
		if (sel < 3) begin
			r.op = OP_CREATE;
		end else if (sel < 23) begin
			r.op = OP_ADD;
			if ($urandom_range(0, 3) != 0)
				r.user_id = user_pool[$urandom_range(0, 15)];
		end else if (sel < 97) begin
			r.op = OP_CHECK;
			sel = $urandom_range(0, 9);
			if (sel == 0)
				r.user_id = '0;
			else if (sel < 7)
				r.user_id = user_pool[$urandom_range(0, 15)];
			if ($urandom_range(0, 3) == 0)
				r.owner_user = r.user_id;
			if ($urandom_range(0, 9) < 7)
				r.owner_group = 8'($urandom_range(0, 7));
			if ($urandom_range(0, 3) == 0)
				r.caller_group = r.owner_group;
		end else begin
			r.op = OP_NONE;
		end
		return r;
	endfunction

	function automatic int pick_idle(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// request side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			idle_left <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				rsp_t exp_rsp;
				if (req.op == OP_ADD && req.group_index < groups_made &&
						member_cnt[req.group_index] == LIST_DEPTH)
					n_full_adds++;
				exp_rsp = access_response(req);
				answer_q.push_back(exp_rsp);
				sent_cnt++;
				case (req.op)
					OP_CREATE: n_create++;
					OP_ADD: begin
						n_add++;
						if (exp_rsp.status)
							n_add_fail++;
					end
					OP_CHECK: begin
						n_check++;
						if (exp_rsp.allowed)
							n_granted++;
					end
					default: n_none++;
				endcase
			end
			if (!req_valid || !req_stall) begin
				if (idle_left > 0) begin
					idle_left <= idle_left - 1;
					req_valid <= 1'b0;
				end else if (request_q.size() != 0) begin
					req <= request_q.pop_front();
					req_valid <= 1'b1;
					idle_left <= pick_idle((sent_cnt / 200) % 3 == 1);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				got_cnt++;
				if (answer_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected transaction status %0b allowed %0b new_group %0d",
						$time, rsp.status, rsp.allowed, rsp.new_group);
				end else begin
					rsp_t exp_rsp;
					exp_rsp = answer_q.pop_front();
					if (rsp.status !== exp_rsp.status) begin
						errors++;
						$display("%0t: status mismatch, expected %0b actual %0b",
							$time, exp_rsp.status, rsp.status);
					end
					if (rsp.allowed !== exp_rsp.allowed) begin
						errors++;
						$display("%0t: allowed mismatch, expected %0b actual %0b",
							$time, exp_rsp.allowed, rsp.allowed);
					end
					if (rsp.new_group !== exp_rsp.new_group) begin
						errors++;
						$display("%0t: new_group mismatch, expected %0d actual %0d",
							$time, exp_rsp.new_group, rsp.new_group);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				rsp_stall <= 1'b1;
			end else begin
				int len;
				len = pick_idle((got_cnt / 200) % 3 == 2);
				rsp_stall <= (len > 0);
				stall_left <= (len > 0) ? len - 1 : 0;
			end
		end
	end

	initial begin
		for (int i = 0; i < 16; i++)
			user_pool[i] = 8'($urandom_range(1, 255));

		// owning group not yet created: caller group match, then others
		request_q.push_back(make_req(OP_CHECK, 0, 5, 3, 6, 3, 9'o070, 7));
		request_q.push_back(make_req(OP_CHECK, 0, 5, 4, 6, 3, 9'o070, 1));
		request_q.push_back(make_req(OP_ADD, 0, 12, 0, 0, 0, 0, 0));
		request_q.push_back(make_req(OP_NONE, 0, 0, 0, 0, 0, 0, 0));
		for (int i = 0; i < GROUP_SLOTS + 1; i++)
			request_q.push_back(make_req(OP_CREATE, 7, 255, 255, 255, 255, 511, 7));
		request_q.push_back(make_req(OP_ADD, 2, 77, 0, 0, 0, 0, 0));
		request_q.push_back(make_req(OP_ADD, 2, 77, 0, 0, 0, 0, 0));
		request_q.push_back(make_req(OP_CHECK, 0, 77, 9, 5, 2, 9'o070, 7));
		request_q.push_back(make_req(OP_CHECK, 0, 0, 9, 5, 2, 0, 7));
		request_q.push_back(make_req(OP_CHECK, 0, 200, 2, 200, 2, 9'o700, 7));
		request_q.push_back(make_req(OP_CHECK, 0, 200, 2, 200, 2, 9'o077, 4));
		request_q.push_back(make_req(OP_CHECK, 0, 9, 1, 5, 2, 9'o007, 7));
		request_q.push_back(make_req(OP_CHECK, 0, 3, 1, 5, 2, 0, 0));
		request_q.push_back(make_req(OP_CHECK, 7, 255, 255, 254, 255, 9'o777, 7));
		request_q.push_back(make_req(OP_ADD, 7, 255, 255, 255, 255, 511, 7));
		request_q.push_back(make_req(OP_NONE, 7, 255, 255, 255, 255, 511, 7));
		for (int i = 0; i < RAND_ITEMS; i++)
			request_q.push_back(random_req());

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (request_q.size() != 0 || req_valid)
			@(posedge clk);
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("%0d transactions: %0d create, %0d add (%0d refused, %0d on full lists)",
			sent_cnt, n_create, n_add, n_add_fail, n_full_adds);
		$display("%0d checks (%0d granted), %0d reserved ops, %0d mismatches",
			n_check, n_granted, n_none, errors);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#6_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
